// ===== hw/rtl/bffl_pkg.sv =====
package bffl_pkg;

  localparam int MAX_BIN_DEF = 64;

  localparam int CountW = 16;
  localparam int LevelW = 24;
  localparam int AccW   = 30;
  localparam int CoefW  = 21;
  localparam int ProjW  = 32;
  localparam int StatW  = 2;
  localparam int FracW  = 24;
  localparam int ExpW   = 5;
  localparam int LogW   = ExpW + FracW;
  localparam int MantW  = 32;
  localparam int TW     = 21;
  localparam int TtW    = 25;
  localparam int QW     = 30;

  localparam logic [AccW-1:0] ACC_MAX = {AccW{1'b1}};
  localparam logic [31:0]     LN2_Q32 = 32'hB172_17F8;

  typedef enum logic [StatW-1:0] {
    ST_OK     = 2'd0,
    ST_ZERO_W = 2'd1,
    ST_ZERO_F = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQ
  } lg_state_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_LOGF,
    C_LOGW,
    C_MULT,
    C_MULTT,
    C_MULQ,
    C_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic in_ready;
    logic log_start;
    logic log_sel_w;
    logic cap_lf;
    logic mul_t;
    logic mul_tt;
    logic mul_q;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic close;
    logic zero_case;
    logic log_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/bffl_log2.sv =====
module bffl_log2 (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [bffl_pkg::AccW-1:0] x_i,
  output logic                    done_o,
  output logic [bffl_pkg::LogW-1:0] log_o
);
  import bffl_pkg::*;

  localparam int CntW = $clog2(FracW);

  lg_state_e            state_q, state_d;
  logic [MantW-1:0]     m_q;
  logic [ExpW-1:0]      e_q;
  logic [FracW-1:0]     frac_q;
  logic [CntW-1:0]      cnt_q;
  logic                 done_q;
  logic [2*MantW-1:0]   sq;
  logic [MantW:0]       sq_top;
  logic                 last_sq;

  assign sq      = m_q * m_q;
  assign sq_top  = sq[2*MantW-1:MantW-1];
  assign last_sq = (state_q == LG_SQ) && (cnt_q == CntW'(FracW - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      LG_IDLE: if (start_i) state_d = LG_NORM;
      LG_NORM: if (m_q[MantW-1]) state_d = LG_SQ;
      LG_SQ:   if (last_sq) state_d = LG_IDLE;
      default: state_d = LG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LG_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= last_sq;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      LG_IDLE: begin
        if (start_i) begin
          m_q    <= {{(MantW-AccW){1'b0}}, x_i};
          e_q    <= ExpW'(MantW - 1);
          frac_q <= '0;
          cnt_q  <= '0;
        end
      end
      LG_NORM: begin
        if (!m_q[MantW-1]) begin
          m_q <= {m_q[MantW-2:0], 1'b0};
          e_q <= e_q - 1'b1;
        end
      end
      LG_SQ: begin
        cnt_q <= cnt_q + 1'b1;
        if (sq_top[MantW]) begin
          frac_q <= {frac_q[FracW-2:0], 1'b1};
          m_q    <= sq_top[MantW:1];
        end else begin
          frac_q <= {frac_q[FracW-2:0], 1'b0};
          m_q    <= sq_top[MantW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign log_o  = {e_q, frac_q};

endmodule

// ===== hw/rtl/bffl_datapath.sv =====
module bffl_datapath #(
  parameter int MaxBin = bffl_pkg::MAX_BIN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [bffl_pkg::CoefW-1:0]    cfg_wr_data_i,
  input  logic                          s_axis_tvalid,
  input  logic [63:0]                   s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [63:0]                   m_axis_tdata,
  input  bffl_pkg::ctrl_cmd_t           cmd_i,
  output bffl_pkg::dp_status_t          sts_o
);
  import bffl_pkg::*;

  localparam int BinCntW = $clog2(MaxBin + 1);

  logic [CountW-1:0]   raw_count;
  logic [LevelW-1:0]   flat_level, dark_level, count_q8;
  logic [LevelW-1:0]   wdiff, fdiff;
  logic [AccW:0]       wsum_raw, fsum_raw;
  logic [AccW-1:0]     wsum, fsum;
  logic                in_fire, close;

  logic [AccW-1:0]     wacc_q, facc_q, wbin_q;
  logic [BinCntW-1:0]  bin_cnt_q, bin_cnt_inc;
  logic [CoefW-1:0]    coef_q;
  status_e             status_q;

  logic                log_done;
  logic [LogW-1:0]     log_res, lf_q;
  logic [AccW-1:0]     log_x;

  logic                neg;
  logic [LogW-1:0]     dmag;
  logic [LogW+31:0]    tprod;
  logic [TW-1:0]       tmag_q;
  logic [2*TW-1:0]     ttprod;
  logic [TtW-1:0]      tt_q;
  logic [CoefW-1:0]    cmag;
  logic [CoefW+TtW-1:0] qprod;
  logic [QW-1:0]       qmag_q;
  logic                neg_q;
  logic signed [ProjW:0] t_s, q_s, psum;
  logic [ProjW-1:0]    proj;

  logic                ovalid_q;
  logic [63:0]         odata_q;

  assign raw_count  = s_axis_tdata[15:0];
  assign flat_level = s_axis_tdata[39:16];
  assign dark_level = s_axis_tdata[63:40];
  assign count_q8   = {raw_count, 8'h00};

  assign wdiff = (count_q8 >= dark_level) ? count_q8 - dark_level : dark_level - count_q8;
  assign fdiff = (flat_level >= dark_level) ? flat_level - dark_level
                                            : dark_level - flat_level;
  assign wsum_raw = {1'b0, wacc_q} + {{(AccW+1-LevelW){1'b0}}, wdiff};
  assign fsum_raw = {1'b0, facc_q} + {{(AccW+1-LevelW){1'b0}}, fdiff};
  assign wsum     = wsum_raw[AccW] ? ACC_MAX : wsum_raw[AccW-1:0];
  assign fsum     = fsum_raw[AccW] ? ACC_MAX : fsum_raw[AccW-1:0];

  assign in_fire     = s_axis_tvalid && cmd_i.in_ready;
  assign bin_cnt_inc = bin_cnt_q + 1'b1;
  assign close       = s_axis_tlast || (bin_cnt_inc >= BinCntW'(MaxBin));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wacc_q    <= '0;
      facc_q    <= '0;
      bin_cnt_q <= '0;
      coef_q    <= '0;
      status_q  <= ST_OK;
      ovalid_q  <= 1'b0;
    end else begin
      if (cfg_wr_en_i) coef_q <= cfg_wr_data_i;
      if (in_fire) begin
        if (close) begin
          wacc_q    <= '0;
          facc_q    <= '0;
          bin_cnt_q <= '0;
          if (wsum == '0)      status_q <= ST_ZERO_W;
          else if (fsum == '0) status_q <= ST_ZERO_F;
          else                 status_q <= ST_OK;
        end else begin
          wacc_q    <= wsum;
          facc_q    <= fsum;
          bin_cnt_q <= bin_cnt_inc;
        end
      end
      if (cmd_i.out_load)     ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  // Closed bin weight sum, held for the second log pass and the output.
  always_ff @(posedge clk_i) begin
    if (in_fire && close) begin
      wbin_q <= wsum;
    end
  end

  // The flat sum goes straight in at the closing edge, where the first pass starts.
  assign log_x = cmd_i.log_sel_w ? wbin_q : fsum;

  bffl_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .log_o   (log_res)
  );

  assign neg    = lf_q < log_res;
  assign dmag   = neg ? log_res - lf_q : lf_q - log_res;
  assign tprod  = dmag * LN2_Q32;
  assign ttprod = tmag_q * tmag_q;
  assign cmag   = coef_q[CoefW-1] ? CoefW'(-coef_q) : coef_q;
  assign qprod  = cmag * tt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_lf) lf_q <= log_res;
    if (cmd_i.mul_t) begin
      tmag_q <= TW'((tprod + (61'(1) << 39)) >> 40);
      neg_q  <= neg;
    end
    if (cmd_i.mul_tt) tt_q   <= TtW'((ttprod + (42'(1) << 15)) >> 16);
    if (cmd_i.mul_q)  qmag_q <= QW'((qprod + (46'(1) << 15)) >> 16);
  end

  // Apply signs and clamp to signed 32 bits.
  assign t_s  = neg_q ? -$signed({{(ProjW+1-TW){1'b0}}, tmag_q})
                      : $signed({{(ProjW+1-TW){1'b0}}, tmag_q});
  assign q_s  = coef_q[CoefW-1] ? -$signed({{(ProjW+1-QW){1'b0}}, qmag_q})
                                : $signed({{(ProjW+1-QW){1'b0}}, qmag_q});
  assign psum = q_s + t_s;

  always_comb begin
    if (status_q != ST_OK)               proj = '0;
    else if (psum[ProjW] != psum[ProjW-1]) proj = psum[ProjW] ? {1'b1, {(ProjW-1){1'b0}}}
                                                            : {1'b0, {(ProjW-1){1'b1}}};
    else                                 proj = psum[ProjW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) odata_q <= {status_q, proj, wbin_q};
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  assign sts_o.in_fire   = in_fire;
  assign sts_o.close     = close;
  assign sts_o.zero_case = (wsum == '0) || (fsum == '0);
  assign sts_o.log_done  = log_done;
  assign sts_o.out_free  = !ovalid_q || m_axis_tready;

endmodule

// ===== hw/rtl/bffl_ctrl.sv =====
module bffl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bffl_pkg::dp_status_t sts_i,
  output bffl_pkg::ctrl_cmd_t  cmd_o
);
  import bffl_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      C_IDLE: begin
        if (sts_i.in_fire && sts_i.close) state_d = sts_i.zero_case ? C_OUT : C_LOGF;
      end
      C_LOGF:  if (sts_i.log_done) state_d = C_LOGW;
      C_LOGW:  if (sts_i.log_done) state_d = C_MULT;
      C_MULT:  state_d = C_MULTT;
      C_MULTT: state_d = C_MULQ;
      C_MULQ:  state_d = C_OUT;
      C_OUT:   if (sts_i.out_free) state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      C_IDLE: begin
        cmd_o.in_ready  = 1'b1;
        cmd_o.log_start = sts_i.in_fire && sts_i.close && !sts_i.zero_case;
      end
      C_LOGF: begin
        cmd_o.cap_lf    = sts_i.log_done;
        cmd_o.log_start = sts_i.log_done;
        cmd_o.log_sel_w = 1'b1;
      end
      C_LOGW:  cmd_o.mul_t    = sts_i.log_done;
      C_MULT:  cmd_o.mul_tt   = 1'b1;
      C_MULTT: cmd_o.mul_q    = 1'b1;
      C_OUT:   cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= C_IDLE;
    else         state_q <= state_d;
  end

endmodule

// ===== hw/rtl/binned_flat_field_log_correction.sv =====
// Binned flat-field correction with log transform. Each request on the slave
// side is one detector subpixel; |count*256-dark| and |flat-dark| go into
// saturating 30-bit sums. The subpixel marked tlast (or the MaxBin-th one of a
// bin) closes the bin and yields one request on the master side: the weight
// sum, t = ln(flat_sum/weight_sum) corrected to coef*t*t + t in signed Q15.16,
// and a status (1 zero weight sum, 2 zero flat sum, projection 0 in both).
// An open-bin subpixel never holds the input off; a closing one holds it off
// until its result is loaded: directly if a sum is zero, else after the shared
// iterative log2 unit has run on the flat sum and then the weight sum (per sum
// one normalising shift per leading zero, i.e. 31 minus the top set bit index,
// one squaring per fraction bit and a done flag) and the t, t*t and coef*t*t
// products. A finished result waits in the output register while new subpixels
// are taken; a later closing bin waits at its load until the register is free.
module binned_flat_field_log_correction #(
  parameter int MaxBin = bffl_pkg::MAX_BIN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wr_en_i,
  input  logic [bffl_pkg::CoefW-1:0] cfg_wr_data_i,  // beam_hardening_coef, Q4.16
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // raw_count[15:0], flat_level[39:16], dark_level[63:40]
  input  logic [63:0]                s_axis_tdata,
  input  logic                       s_axis_tlast,   // last_in_bin
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // weight_sum[29:0], projection_value[61:30], status[63:62]
  output logic [63:0]                m_axis_tdata
);
  import bffl_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // Sequence the log and multiply steps of a closed bin.
  bffl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Accumulators, log unit, multipliers and output register.
  bffl_datapath #(
    .MaxBin (MaxBin)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

  assign s_axis_tready = cmd.in_ready;

endmodule

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bffl_pkg::*;

  // Bin-close predictor and queue of expected bin results.
  class bin_scoreboard;
    logic [AccW-1:0] weight_acc;
    logic [AccW-1:0] flat_acc;
    int unsigned     pix_count;
    logic signed [CoefW-1:0] coef;
    logic [63:0]     expected_q[$];
    int              errors;

    function new();
      weight_acc = '0;
      flat_acc   = '0;
      pix_count  = 0;
      coef       = '0;
      errors     = 0;
    endfunction

    function automatic logic [29:0] log2_q24(logic [AccW-1:0] x);
      int          e;
      logic [23:0] frac;
      logic [63:0] m;
      e    = 0;
      frac = '0;
      for (int i = AccW - 1; i >= 0; i--) begin
        if (x[i]) begin
          e = i;
          break;
        end
      end
      m = 64'(x) << (31 - e);
      for (int i = 0; i < FracW; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m >= 64'h1_0000_0000) begin
          frac[0] = 1'b1;
          m = m >> 1;
        end
      end
      return {e[5:0], frac};
    endfunction

    function automatic logic [AccW-1:0] sat_sum(logic [AccW-1:0] a, logic [23:0] b);
      logic [AccW:0] s;
      s = {1'b0, a} + (AccW + 1)'(b);
      return s > (AccW + 1)'(ACC_MAX) ? ACC_MAX : s[AccW-1:0];
    endfunction

    function automatic logic [23:0] absdiff(logic [23:0] a, logic [23:0] b);
      return a >= b ? a - b : b - a;
    endfunction

    // Fold one accepted subpixel in; queue a result when the bin closes.
    function void note_subpixel(logic [63:0] data, logic last);
      logic [23:0] cnt;
      logic [AccW-1:0] w, f;
      logic [29:0] lf, lw;
      logic [63:0] d, tmag, tt, cmag, qmag;
      longint signed proj;
      status_e st;
      cnt = {data[15:0], 8'h00};
      weight_acc = sat_sum(weight_acc, absdiff(cnt, data[63:40]));
      flat_acc   = sat_sum(flat_acc, absdiff(data[39:16], data[63:40]));
      pix_count++;
      if (!last && pix_count < MAX_BIN_DEF) return;
      w = weight_acc;
      f = flat_acc;
      proj = 0;
      if (w == 0) begin
        st = ST_ZERO_W;
      end else if (f == 0) begin
        st = ST_ZERO_F;
      end else begin
        st = ST_OK;
        lf = log2_q24(f);
        lw = log2_q24(w);
        d = lf < lw ? 64'(lw - lf) : 64'(lf - lw);
        tmag = (d * 64'(LN2_Q32) + (64'd1 << 39)) >> 40;
        tt = (tmag * tmag + (64'd1 << 15)) >> 16;
        cmag = coef < 0 ? 64'(-longint'(coef)) : 64'(longint'(coef));
        qmag = (cmag * tt + (64'd1 << 15)) >> 16;
        proj = (coef < 0 ? -longint'(qmag) : longint'(qmag))
             + (lf < lw ? -longint'(tmag) : longint'(tmag));
        if (proj > 64'sd2147483647) proj = 64'sd2147483647;
        if (proj < -64'sd2147483648) proj = -64'sd2147483648;
      end
      expected_q.push_back({st, proj[31:0], w});
      weight_acc = '0;
      flat_acc   = '0;
      pix_count  = 0;
    endfunction

    function void check_bin(logic [63:0] got);
      logic [63:0] exp_v;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected bin result %h", $time, got);
        errors++;
        return;
      end
      exp_v = expected_q.pop_front();
      if (got[29:0] !== exp_v[29:0]) begin
        $display("%0t weight_sum exp %h got %h", $time, exp_v[29:0], got[29:0]);
        errors++;
      end
      if (got[61:30] !== exp_v[61:30]) begin
        $display("%0t projection exp %h got %h", $time, exp_v[61:30], got[61:30]);
        errors++;
      end
      if (got[63:62] !== exp_v[63:62]) begin
        $display("%0t status exp %0d got %0d", $time, exp_v[63:62], got[63:62]);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_wr_en_i = 1'b0;
  logic [CoefW-1:0]  cfg_wr_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [63:0]       m_axis_tdata;

  bin_scoreboard sb = new();
  int            cycles = 0;
  bit            hold_sink = 1'b0;

  localparam int CycleLimit = 1_500_000;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  binned_flat_field_log_correction u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Draw a gap length: mostly zero or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Watchdog: abort the run well past the slowest legal run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Check every accepted bin result.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_bin(m_axis_tdata);
  end

  // Sink: random back-pressure, or a long hold of its own count when asked.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        m_axis_tready <= 1'b1;
        while (hold_sink) @(posedge clk_i);
      end else begin
        g = gap_len();
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk_i);
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offer one subpixel request and hold it until the block takes it.
  task automatic send_pixel(logic [15:0] cnt, logic [23:0] flat, logic [23:0] dark,
                            logic last, bit no_gap = 1'b0);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dark, flat, cnt};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_subpixel({dark, flat, cnt}, last);
  endtask

  task automatic idle_source();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain all pending results, then allow the closing log pass to settle.
  task automatic drain();
    idle_source();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_coef(logic [CoefW-1:0] v);
    drain();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    sb.coef = v;
    @(posedge clk_i);
  endtask

  // Random subpixel; mix narrow values and the full field range.
  task automatic random_pixel(logic last);
    logic [15:0] c;
    logic [23:0] fl, dk;
    c  = 16'($urandom);
    fl = 24'($urandom);
    dk = 24'($urandom);
    case ($urandom_range(5))
      0: dk = 24'({c, 8'h00} + $urandom_range(0, 512));
      1: fl = dk;
      2: begin
        c  = 16'($urandom_range(0, 300));
        dk = 24'($urandom_range(0, 4096));
        fl = 24'($urandom_range(0, 1 << 20));
      end
      default: ;
    endcase
    send_pixel(c, fl, dk, last);
  endtask

  initial begin
    int n;
    int sent;
    logic [CoefW-1:0] coefs[6];
    coefs = '{21'h000000, 21'h0FFFFF, 21'h100000, 21'h010000, 21'h1F0000, 21'h004000};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, zero sums, near full-scale sums and an over-long bin.
    send_pixel(16'h0000, 24'h000000, 24'h000000, 1'b1);
    send_pixel(16'h0001, 24'h000000, 24'h000000, 1'b1);
    send_pixel(16'h0000, 24'h000100, 24'h000000, 1'b1);
    send_pixel(16'hFFFF, 24'hFFFFFF, 24'h000000, 1'b1);
    send_pixel(16'h0000, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    send_pixel(16'h0100, 24'h010000, 24'h000000, 1'b1);
    send_pixel(16'h0001, 24'hFFFFFF, 24'h000000, 1'b1);
    send_pixel(16'hFFFF, 24'h000001, 24'h000000, 1'b1);
    write_coef(21'h0FFFFF);
    send_pixel(16'h0001, 24'hFFFFFF, 24'h000000, 1'b1);
    send_pixel(16'hFFFF, 24'h000001, 24'h000000, 1'b1);
    write_coef(21'h100000);
    send_pixel(16'h0001, 24'hFFFFFF, 24'h000000, 1'b1);
    send_pixel(16'hFFFF, 24'h000001, 24'h000000, 1'b1);
    // Drive both sums close to full scale, then exceed the bin length limit.
    for (int i = 0; i < MAX_BIN_DEF + 3; i++)
      send_pixel(16'hFFFF, 24'hFFFFFF, 24'h000000, 1'b0);
    send_pixel(16'h1234, 24'h00ABCD, 24'h000100, 1'b1);

    // Random bins over several coefficient settings.
    sent = 0;
    for (int k = 0; k < 6; k++) begin
      write_coef(k == 5 ? 21'($urandom) : coefs[k]);
      while (sent < (k + 1) * 75) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 6);
        for (int j = 0; j < n; j++) begin
          random_pixel((j == n - 1) && ($urandom_range(19) != 0));
          sent++;
        end
      end
      if (k == 2) begin
        // Hold the sink off while bins keep closing, so the input stalls.
        hold_sink = 1'b1;
        for (int j = 0; j < 12; j++)
          send_pixel(16'($urandom), 24'($urandom), 24'($urandom), 1'b1, 1'b1);
        hold_sink = 1'b0;
      end
    end

    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== binned_flat_field_log_correction.f =====
hw/rtl/bffl_pkg.sv
hw/rtl/bffl_log2.sv
hw/rtl/bffl_datapath.sv
hw/rtl/bffl_ctrl.sv
hw/rtl/binned_flat_field_log_correction.sv
sim/tb.sv
